// File: rtl/core/wvbd_pkg.sv
// Shared types and constants of the window versus baseline drift detector.
package wvbd_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_HISTORY   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_K   = 2'd2;

  // input operations
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam int WLEN_BITS = 7;
  localparam int MINH_BITS = 16;
  localparam int K_BITS    = 8;

  localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RESET = 7'd16;
  localparam logic [MINH_BITS-1:0] MIN_HISTORY_RESET   = 16'd32;
  localparam logic [K_BITS-1:0]    THRESHOLD_K_RESET   = 8'd32;

  // result fields
  localparam int RMEAN_BITS = 16;
  localparam int AVG_BITS   = 24;
  localparam int COUNT_BITS = 32;
  localparam int M2_BITS    = 64;

  // shared arithmetic unit
  localparam int HALF_BITS = 32;
  localparam int OPND_BITS = 64;
  localparam int PROD_BITS = 128;

  typedef struct packed {
    logic start;
    logic divide;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

// File: rtl/core/wvbd_if.sv
// Valid/ready channels for samples in and results out.
interface wvbd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] error_value;

  modport source (output valid, op, error_value, input ready);
  modport sink (input valid, op, error_value, output ready);
endinterface

interface wvbd_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     drift;
  logic signed [wvbd_pkg::RMEAN_BITS-1:0]   window_mean;
  logic signed [wvbd_pkg::AVG_BITS-1:0]     baseline_avg;
  logic        [wvbd_pkg::COUNT_BITS-1:0]   baseline_samples;

  modport source (output valid, drift, window_mean, baseline_avg, baseline_samples,
                  input ready);
  modport sink (input valid, drift, window_mean, baseline_avg, baseline_samples,
                output ready);
endinterface

// File: rtl/core/wvbd_ram.sv
// Generic simple dual-port RAM with registered read.
module wvbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/wvbd_arith.sv
// Shared multi-cycle unit: 64x64 multiply from 32x32 partial products, restoring divide.
module wvbd_arith #(
  parameter int DIV_BITS = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wvbd_pkg::arith_cmd_t             cmd,
  input  logic [wvbd_pkg::OPND_BITS-1:0]   op_a,
  input  logic [wvbd_pkg::OPND_BITS-1:0]   op_b,
  output logic [wvbd_pkg::PROD_BITS-1:0]   result,
  output wvbd_pkg::arith_stat_t            stat
);

  localparam int HB       = wvbd_pkg::HALF_BITS;
  localparam int OB       = wvbd_pkg::OPND_BITS;
  localparam int PB       = wvbd_pkg::PROD_BITS;
  localparam int DVS_BITS = wvbd_pkg::COUNT_BITS;
  localparam int MUL_STEPS = 5;
  localparam int CW = $clog2(((DIV_BITS > MUL_STEPS) ? DIV_BITS : MUL_STEPS) + 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(MUL_STEPS - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DIV_BITS - 1);

  logic          busy;
  logic          done;
  logic          divide;
  logic [CW-1:0] cnt;

  logic [OB-1:0]       a_reg;
  logic [OB-1:0]       b_reg;
  logic [2*HB-1:0]     pp;
  logic [1:0]          pp_sh;
  logic [PB-1:0]       acc;
  logic [PB-1:0]       pp_wide;
  logic [HB-1:0]       a_half;
  logic [HB-1:0]       b_half;

  logic [DIV_BITS-1:0] dvd;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS+1:0] diff;
  logic                q_bit;

  always_comb begin
    a_half = cnt[1] ? a_reg[OB-1:HB] : a_reg[HB-1:0];
    b_half = cnt[0] ? b_reg[OB-1:HB] : b_reg[HB-1:0];
    case (pp_sh)
      2'd0:    pp_wide = {{(PB-2*HB){1'b0}}, pp};
      2'd1:    pp_wide = {{(PB-3*HB){1'b0}}, pp, {HB{1'b0}}};
      2'd2:    pp_wide = {pp, {(2*HB){1'b0}}};
      default: pp_wide = '0;
    endcase
    rem_sh = {rem, dvd[DIV_BITS-1]};
    diff   = {1'b0, rem_sh} - {2'b0, dvs};
    q_bit  = !diff[DVS_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      divide <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy   <= 1'b1;
        divide <= cmd.divide;
        cnt    <= '0;
      end else if (busy) begin
        if (divide ? (cnt == DIV_LAST) : (cnt == MUL_LAST)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_reg <= op_a;
      b_reg <= op_b;
      acc   <= '0;
      dvd   <= op_a[DIV_BITS-1:0];
      dvs   <= op_b[DVS_BITS-1:0];
      rem   <= '0;
    end else if (busy) begin
      if (divide) begin
        dvd <= {dvd[DIV_BITS-2:0], q_bit};
        rem <= q_bit ? diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
      end else begin
        // partial product registered, then accumulated from that register
        if (cnt != MUL_LAST) begin
          pp    <= (2*HB)'(a_half) * (2*HB)'(b_half);
          pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt != '0) begin
          acc <= acc + pp_wide;
        end
      end
    end
  end

  assign result = divide ? {{(PB-DIV_BITS){1'b0}}, dvd} : acc;
  assign stat   = '{busy: busy, done: done};

endmodule

// File: rtl/core/window_vs_baseline_drift_detector_unit.sv
// Top level of the window versus baseline drift detector.
// Usage:
//   samples carries one transaction per error sample (op = 0) or clear (op = 1).
//   Each update writes the ring of the last window_length samples, tests the
//   window mean against the Welford baseline mean plus k/16 standard deviations
//   (squared form, no root), then folds the sample into the baseline.
//   results carries exactly one transaction per accepted input.
//   Configuration: cfg_write, cfg_index, cfg_data; the user writes only while
//   idle (not enforced); writing window_length empties window, keeps baseline.
// Sequencing: one item at a time. An update runs the drift test when it is due
//   (a mean product, plus further products when the window mean leads the
//   baseline mean), then the baseline update; a clear goes straight to the
//   result register. Input is ready again when the result register loads.
//   All products and quotients come from the shared multiply/divide unit,
//   whose divides give DIVW = SAMPLE_BITS + 9 quotient bits at default window
//   sizes.
// Reset clears control, window and baseline state and loads register defaults;
//   ring contents are not cleared (entries are read only once written).
// A stalled receiver holds the result register; the next item may be taken
//   meanwhile and waits for the register before its result is posted.
module window_vs_baseline_drift_detector_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [wvbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wvbd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  wvbd_in_if.sink                               samples,
  wvbd_out_if.source                            results
);

  localparam int SW   = SAMPLE_BITS;
  localparam int MW   = SW + 8;
  localparam int LW   = $clog2(WINDOW_MAX + 1);
  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int TW   = SW + $clog2(WINDOW_MAX) + 1;
  localparam int DW   = ((TW + 8 > MW + LW) ? TW + 8 : MW + LW) + 2;
  localparam int DIVW = (MW + 1 > TW) ? MW + 1 : TW;
  localparam int OB   = wvbd_pkg::OPND_BITS;
  localparam int PB   = wvbd_pkg::PROD_BITS;
  localparam int CB   = wvbd_pkg::COUNT_BITS;
  localparam int M2B  = wvbd_pkg::M2_BITS;
  localparam int RB   = wvbd_pkg::RMEAN_BITS;
  localparam int VB   = wvbd_pkg::AVG_BITS;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RING = 14'b00000000000010,
    S_ML   = 14'b00000000000100,
    S_SQ   = 14'b00000000001000,
    S_LC   = 14'b00000000010000,
    S_KK   = 14'b00000000100000,
    S_KL1  = 14'b00000001000000,
    S_KL2  = 14'b00000010000000,
    S_RM   = 14'b00000100000000,
    S_UPD  = 14'b00001000000000,
    S_DV   = 14'b00010000000000,
    S_PR   = 14'b00100000000000,
    S_RMN  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t state;
  logic   launched;

  // configuration
  logic [wvbd_pkg::WLEN_BITS-1:0] window_length;
  logic [wvbd_pkg::MINH_BITS-1:0] min_history;
  logic [wvbd_pkg::K_BITS-1:0]    threshold_k;
  logic [LW-1:0]                  len;

  // window and baseline state
  logic [AW-1:0]        write_pos;
  logic [LW-1:0]        fill;
  logic signed [TW-1:0] total;
  logic [CB-1:0]        count;
  logic signed [MW-1:0] mean;
  logic [M2B-1:0]       m2;
  logic                 flag;

  // working registers
  logic signed [SW-1:0] sample;
  logic [MW:0]          delta;
  logic [DW-1:0]        gap;
  logic [OB-1:0]        wide_tmp;
  logic [PB-1:0]        lhs;
  logic [RB-1:0]        res_rmean;

  // result register
  logic          out_valid;
  logic          out_drift;
  logic [RB-1:0] out_rmean;
  logic [VB-1:0] out_avg;
  logic [CB-1:0] out_count;

  // arithmetic unit
  wvbd_pkg::arith_cmd_t  arith_cmd;
  wvbd_pkg::arith_stat_t arith_stat;
  logic [OB-1:0]         op_a;
  logic [OB-1:0]         op_b;
  logic [PB-1:0]         arith_res;

  // ring
  logic [SW-1:0] ring_rdata;

  logic                 take;
  logic                 load;
  logic                 computing;
  logic signed [MW-1:0] x_val;
  logic [MW-1:0]        mean_mag;
  logic [MW:0]          delta_mag;
  logic [MW:0]          delta_calc;
  logic [MW:0]          d2;
  logic [MW:0]          d2_mag;
  logic [TW-1:0]        total_mag;
  logic [TW-1:0]        e_ext;
  logic [TW-1:0]        old_ext;
  logic                 pos_wrap;
  logic                 test_go;
  logic [DW-1:0]        tot_sh;
  logic [DW-1:0]        ml;
  logic [DW-1:0]        gap_calc;
  logic                 gap_pos;
  logic [MW:0]          q_delta;
  logic [MW:0]          mean_step;
  logic [MW:0]          mean_upd;
  logic                 prod_pos;
  logic [M2B:0]         m2_sum;
  logic                 m2_sat;
  logic [TW-1:0]        qt;
  logic [TW-1:0]        rmean_full;
  logic [TW+RB-1:0]     rmean_ext;
  logic [MW+VB-1:0]     avg_ext;

  always_comb begin
    if (window_length == '0) begin
      len = LW'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      len = LW'(WINDOW_MAX);
    end else begin
      len = LW'(window_length);
    end
  end

  assign take = samples.valid && samples.ready;
  assign load = (state == S_DONE) && (!out_valid || results.ready);
  assign computing = state inside {S_ML, S_SQ, S_LC, S_KK, S_KL1, S_KL2, S_RM,
                                   S_DV, S_PR, S_RMN};

  always_comb begin
    x_val      = {sample, 8'b0};
    mean_mag   = mean[MW-1] ? $unsigned(-mean) : $unsigned(mean);
    delta_mag  = delta[MW] ? (~delta + 1'b1) : delta;
    delta_calc = {x_val[MW-1], x_val} - {mean[MW-1], mean};
    d2         = {x_val[MW-1], x_val} - {mean[MW-1], mean};
    d2_mag     = d2[MW] ? (~d2 + 1'b1) : d2;
    total_mag  = total[TW-1] ? $unsigned(-total) : $unsigned(total);
    e_ext      = {{(TW-SW){sample[SW-1]}}, sample};
    old_ext    = {{(TW-SW){ring_rdata[SW-1]}}, ring_rdata};
    pos_wrap   = (32'(write_pos) + 32'd1) == 32'(len);
    test_go    = ((fill == len) || ((32'(fill) + 32'd1) == 32'(len)))
                 && (count >= CB'(min_history)) && (count != '0);

    // D = total*256 - mean*len
    tot_sh   = {{(DW-TW-8){total[TW-1]}}, total, 8'b0};
    ml       = arith_res[DW-1:0];
    gap_calc = mean[MW-1] ? (tot_sh + ml) : (tot_sh - ml);
    gap_pos  = !gap_calc[DW-1] && (gap_calc != '0);

    q_delta   = arith_res[MW:0];
    mean_step = delta[MW] ? (~q_delta + 1'b1) : q_delta;
    mean_upd  = {mean[MW-1], mean} + mean_step;

    prod_pos = (delta != '0) && (d2 != '0) && (delta[MW] == d2[MW]);
    m2_sum   = {1'b0, m2} + {1'b0, arith_res[M2B-1:0]};
    m2_sat   = m2_sum[M2B] || (arith_res[PB-1:M2B] != '0);

    qt         = arith_res[TW-1:0];
    rmean_full = total[TW-1] ? (~qt + 1'b1) : qt;
    rmean_ext  = {{RB{rmean_full[TW-1]}}, rmean_full};
    avg_ext    = {{VB{mean[MW-1]}}, mean};
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_ML: begin
        op_a = OB'(mean_mag);
        op_b = OB'(len);
      end
      S_SQ: begin
        op_a = OB'(gap);
        op_b = OB'(gap);
      end
      S_LC: begin
        op_a = wide_tmp;
        op_b = OB'({count, 8'b0});
      end
      S_KK: begin
        op_a = OB'(threshold_k);
        op_b = OB'(threshold_k);
      end
      S_KL1, S_KL2: begin
        op_a = wide_tmp;
        op_b = OB'(len);
      end
      S_RM: begin
        op_a = wide_tmp;
        op_b = m2;
      end
      S_DV: begin
        op_a = OB'(delta_mag);
        op_b = OB'(count);
      end
      S_PR: begin
        op_a = OB'(delta_mag);
        op_b = OB'(d2_mag);
      end
      S_RMN: begin
        op_a = OB'(total_mag);
        op_b = OB'(fill);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign arith_cmd.start  = computing && !launched;
  assign arith_cmd.divide = (state == S_DV) || (state == S_RMN);

  wvbd_arith #(
    .DIV_BITS (DIVW)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (arith_cmd),
    .op_a   (op_a),
    .op_b   (op_b),
    .result (arith_res),
    .stat   (arith_stat)
  );

  wvbd_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_RING),
    .waddr (write_pos),
    .wdata (sample),
    .raddr (write_pos),
    .rdata (ring_rdata)
  );

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      launched      <= 1'b0;
      window_length <= wvbd_pkg::WINDOW_LENGTH_RESET;
      min_history   <= wvbd_pkg::MIN_HISTORY_RESET;
      threshold_k   <= wvbd_pkg::THRESHOLD_K_RESET;
      write_pos     <= '0;
      fill          <= '0;
      total         <= '0;
      count         <= '0;
      mean          <= '0;
      m2            <= '0;
      flag          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (arith_cmd.start) begin
        launched <= 1'b1;
      end else if (arith_stat.done) begin
        launched <= 1'b0;
      end

      if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (take) begin
            if (samples.op == wvbd_pkg::OP_CLEAR) begin
              write_pos <= '0;
              fill      <= '0;
              total     <= '0;
              count     <= '0;
              mean      <= '0;
              m2        <= '0;
              flag      <= 1'b0;
              state     <= S_DONE;
            end else begin
              state <= S_RING;
            end
          end
        end
        S_RING: begin
          if (fill == len) begin
            total <= total + $signed(e_ext) - $signed(old_ext);
          end else begin
            total <= total + $signed(e_ext);
            fill  <= fill + 1'b1;
          end
          write_pos <= pos_wrap ? '0 : write_pos + 1'b1;
          flag      <= 1'b0;
          state     <= test_go ? S_ML : S_UPD;
        end
        S_ML: begin
          if (arith_stat.done) begin
            state <= gap_pos ? S_SQ : S_UPD;
          end
        end
        S_SQ: begin
          if (arith_stat.done) state <= S_LC;
        end
        S_LC: begin
          if (arith_stat.done) state <= S_KK;
        end
        S_KK: begin
          if (arith_stat.done) state <= S_KL1;
        end
        S_KL1: begin
          if (arith_stat.done) state <= S_KL2;
        end
        S_KL2: begin
          if (arith_stat.done) state <= S_RM;
        end
        S_RM: begin
          if (arith_stat.done) begin
            flag  <= lhs > arith_res;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (count != {CB{1'b1}}) begin
            count <= count + 1'b1;
          end
          state <= S_DV;
        end
        S_DV: begin
          if (arith_stat.done) begin
            mean  <= mean_upd[MW-1:0];
            state <= S_PR;
          end
        end
        S_PR: begin
          if (arith_stat.done) begin
            if (prod_pos) begin
              m2 <= m2_sat ? {M2B{1'b1}} : m2_sum[M2B-1:0];
            end
            state <= S_RMN;
          end
        end
        S_RMN: begin
          if (arith_stat.done) state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_write) begin
        case (cfg_index)
          wvbd_pkg::REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[wvbd_pkg::WLEN_BITS-1:0];
            write_pos     <= '0;
            fill          <= '0;
            total         <= '0;
          end
          wvbd_pkg::REG_MIN_HISTORY: min_history <= cfg_data[wvbd_pkg::MINH_BITS-1:0];
          wvbd_pkg::REG_THRESHOLD_K: threshold_k <= cfg_data[wvbd_pkg::K_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      sample    <= samples.error_value;
      res_rmean <= '0;
    end
    case (state)
      S_ML: begin
        if (arith_stat.done) gap <= gap_calc;
      end
      S_SQ, S_KK, S_KL1, S_KL2: begin
        if (arith_stat.done) wide_tmp <= arith_res[OB-1:0];
      end
      S_LC: begin
        if (arith_stat.done) lhs <= arith_res;
      end
      S_UPD: delta <= delta_calc;
      S_RMN: begin
        if (arith_stat.done) res_rmean <= rmean_ext[RB-1:0];
      end
      S_DONE: begin
        if (load) begin
          out_drift <= flag;
          out_rmean <= res_rmean;
          out_avg   <= avg_ext[VB-1:0];
          out_count <= count;
        end
      end
      default: ;
    endcase
  end

  assign samples.ready            = (state == S_IDLE);
  assign results.valid            = out_valid;
  assign results.drift            = out_drift;
  assign results.window_mean      = out_rmean;
  assign results.baseline_avg     = out_avg;
  assign results.baseline_samples = out_count;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    take |=> !samples.ready)
    else $error("second transaction accepted while an item is in work");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (fill <= len))
    else $error("window fill exceeds window length");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (32'(write_pos) < 32'(len)))
    else $error("ring write position outside window");

  a_arith_free: assert property (@(posedge clk) disable iff (rst)
    arith_cmd.start |-> !arith_stat.busy)
    else $error("arithmetic unit started while busy");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> (count != '0))
    else $error("baseline count zero before mean division");

endmodule

// File: dv/tb_top.sv
// Self-checking bench for the drift detector: predicts each result and compares it on the fly.
`timescale 1ns / 100ps

module tb_top;
  import wvbd_pkg::*;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] value;
  } sample_item_t;

  typedef struct {
    logic                     drift;
    logic signed [RMEAN_BITS-1:0] rmean;
    logic signed [AVG_BITS-1:0]   avg;
    logic [COUNT_BITS-1:0]        count;
  } drift_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  wvbd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
  wvbd_out_if                             result_bus ();

  window_vs_baseline_drift_detector_unit #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (sample_bus),
    .results  (result_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sample_item_t  pending_samples[$];
  drift_result_t due_results[$];
  int            err_count = 0;
  int            cyc_count = 0;

  // ---------------------------------------------------------------- predictor
  logic [WLEN_BITS-1:0]          cur_wlen;
  logic [MINH_BITS-1:0]          cur_minh;
  logic [K_BITS-1:0]             cur_k;
  logic signed [SAMPLE_BITS-1:0] win_ring [WINDOW_MAX];
  int unsigned                   win_pos;
  int unsigned                   win_fill;
  longint                        win_sum;
  logic [COUNT_BITS-1:0]         base_n;
  longint                        base_avg;   // Q16.8
  logic [M2_BITS-1:0]            base_var;   // M2, units of 2^-16

  function automatic void empty_window();
    win_pos  = 0;
    win_fill = 0;
    win_sum  = 0;
  endfunction

  function automatic void clear_detector();
    empty_window();
    base_n   = '0;
    base_avg = 0;
    base_var = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    if (idx == REG_WINDOW_LENGTH) begin
      cur_wlen = data[WLEN_BITS-1:0];
      empty_window();
    end else if (idx == REG_MIN_HISTORY) begin
      cur_minh = data[MINH_BITS-1:0];
    end else if (idx == REG_THRESHOLD_K) begin
      cur_k = data[K_BITS-1:0];
    end
  endfunction

  function automatic drift_result_t drift_predict(input logic op,
                                                  input logic signed [SAMPLE_BITS-1:0] ev);
    drift_result_t     r;
    int unsigned       len;
    int unsigned       pos;
    longint            e;
    longint            x;
    longint            delta;
    longint            delta2;
    longint            prod;
    longint            d;
    longint            sq;
    logic [63:0]       kk;
    logic [127:0]      lhs;
    logic [127:0]      rhs;
    logic [64:0]       acc;
    logic              flag;
    r.drift = 1'b0;
    r.rmean = '0;
    r.avg   = '0;
    r.count = '0;
    if (op == OP_CLEAR) begin
      clear_detector();
      return r;
    end
    len = (cur_wlen == 0) ? 1 : (cur_wlen > WINDOW_MAX) ? WINDOW_MAX : cur_wlen;
    e   = longint'(ev);
    pos = win_pos % len;
    if (win_fill < len) begin
      win_sum  = win_sum + e;
      win_fill = win_fill + 1;
    end else begin
      win_sum = win_sum + e - longint'(win_ring[pos]);
    end
    win_ring[pos] = ev;
    win_pos = (pos + 1) % len;

    // drift test uses the baseline before this sample joins it
    flag = 1'b0;
    if (win_fill == len && base_n >= cur_minh && base_n != 0) begin
      d = win_sum * 256 - base_avg * longint'(len);
      if (d > 0) begin
        sq  = d * d;
        lhs = {64'd0, sq} * {88'd0, base_n, 8'd0};
        kk  = cur_k;
        kk  = kk * kk * len * len;
        rhs = {64'd0, kk} * {64'd0, base_var};
        flag = lhs > rhs;
      end
    end

    x = e * 256;
    if (base_n != '1) base_n = base_n + 1;
    delta    = x - base_avg;
    base_avg = base_avg + delta / longint'(base_n);
    delta2   = x - base_avg;
    prod     = delta * delta2;
    if (prod > 0) begin
      acc = {1'b0, base_var} + {1'b0, prod};
      base_var = acc[64] ? '1 : acc[63:0];
    end

    r.drift = flag;
    r.rmean = (win_fill != 0) ? RMEAN_BITS'(win_sum / longint'(win_fill)) : '0;
    r.avg   = base_avg[AVG_BITS-1:0];
    r.count = base_n;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  sample_item_t next_item;
  int           burst_left;
  int           gap_left;

  always @(posedge clk) begin
    if (rst) begin
      sample_bus.valid       <= 1'b0;
      sample_bus.op          <= OP_UPDATE;
      sample_bus.error_value <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!sample_bus.valid || sample_bus.ready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        sample_bus.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        next_item = pending_samples.pop_front();
        sample_bus.valid       <= 1'b1;
        sample_bus.op          <= next_item.op;
        sample_bus.error_value <= next_item.value;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(40, 150);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end else begin
        sample_bus.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: runs of always-ready, coin-flip, and long holds
  int stall_mode;
  int mode_left;

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 400);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0:       result_bus.ready <= 1'b1;
        1:       result_bus.ready <= 1'($urandom_range(0, 1));
        default: result_bus.ready <= ($urandom_range(0, 60) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  drift_result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_bus.valid && sample_bus.ready)
        due_results = {due_results, drift_predict(sample_bus.op, sample_bus.error_value)};
      if (result_bus.valid && result_bus.ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (result_bus.drift !== want.drift) begin
            $error("drift: expected %0d, actual %0d", want.drift, result_bus.drift);
            err_count++;
          end
          if (result_bus.window_mean !== want.rmean) begin
            $error("window_mean: expected %0d, actual %0d", want.rmean,
                   result_bus.window_mean);
            err_count++;
          end
          if (result_bus.baseline_avg !== want.avg) begin
            $error("baseline_avg: expected %0d, actual %0d", want.avg,
                   result_bus.baseline_avg);
            err_count++;
          end
          if (result_bus.baseline_samples !== want.count) begin
            $error("baseline_samples: expected %0d, actual %0d", want.count,
                   result_bus.baseline_samples);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [SAMPLE_BITS-1:0] sat16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic void push_item(input logic op, input logic signed [SAMPLE_BITS-1:0] v);
    sample_item_t it;
    it.op    = op;
    it.value = v;
    pending_samples = {pending_samples, it};
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_bus.valid || due_results.size() != 0);
  endtask

  task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, data);
  endtask

  // window length and k carry random junk above their fields; only the low bits count
  task automatic write_regs(input logic [WLEN_BITS-1:0] wl, input logic [MINH_BITS-1:0] mh,
                            input logic [K_BITS-1:0] kq);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    cfg_put(REG_WINDOW_LENGTH, {junk[CFG_DATA_BITS-1:WLEN_BITS], wl});
    junk = CFG_DATA_BITS'($urandom);
    cfg_put(REG_MIN_HISTORY, mh);
    cfg_put(REG_THRESHOLD_K, {junk[CFG_DATA_BITS-1:K_BITS], kq});
    @(negedge clk);
  endtask

  // steady baseline around a level, then a shifted stretch; plus noise and clears
  task automatic gen_traffic(input int n);
    int made;
    int lvl;
    int amp;
    int jump;
    int k1;
    int k2;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0: begin
          push_item(OP_CLEAR, SAMPLE_BITS'($urandom));
          made++;
        end
        1, 2: begin
          k1 = $urandom_range(1, 12);
          repeat (k1) push_item(OP_UPDATE, SAMPLE_BITS'($urandom));
          made += k1;
        end
        default: begin
          lvl = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                            : int'($urandom_range(0, 8000)) - 4000;
          case ($urandom_range(0, 3))
            0: amp = 0;
            1: amp = 8;
            2: amp = 256;
            default: amp = 4096;
          endcase
          jump = int'($urandom_range(0, 6 * amp + 64));
          if ($urandom_range(0, 3) == 0) jump = -jump;
          k1 = $urandom_range(10, 70);
          k2 = $urandom_range(4, 70);
          repeat (k1)
            push_item(OP_UPDATE, sat16(lvl + int'($urandom_range(0, 2 * amp)) - amp));
          repeat (k2)
            push_item(OP_UPDATE,
                      sat16(lvl + jump + int'($urandom_range(0, 2 * amp)) - amp));
          made += k1 + k2;
        end
      endcase
    end
  endtask

  logic [WLEN_BITS-1:0] pick_wl;
  logic [MINH_BITS-1:0] pick_mh;
  logic [K_BITS-1:0]    pick_k;

  initial begin
    sample_bus.valid       = 1'b0;
    sample_bus.op          = OP_UPDATE;
    sample_bus.error_value = '0;
    result_bus.ready       = 1'b0;
    cur_wlen = WINDOW_LENGTH_RESET;
    cur_minh = MIN_HISTORY_RESET;
    cur_k    = THRESHOLD_K_RESET;
    clear_detector();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults: field extremes, alternating bit patterns, a clear
    push_item(OP_UPDATE, 16'sh7fff);
    push_item(OP_UPDATE, -16'sh8000);
    push_item(OP_UPDATE, 16'sh0000);
    push_item(OP_UPDATE, 16'sh0001);
    push_item(OP_UPDATE, -16'sh0001);
    push_item(OP_UPDATE, 16'sh5555);
    push_item(OP_UPDATE, -16'sh5556);
    push_item(OP_CLEAR, 16'sh7fff);
    push_item(OP_UPDATE, -16'sh8000);
    wait_idle();

    // length 0 acts as 1; empty baseline; k of zero compares means only
    write_regs(7'd0, 16'd0, 8'd0);
    push_item(OP_UPDATE, 16'sh0100);
    push_item(OP_UPDATE, 16'sh0200);
    push_item(OP_UPDATE, 16'sh0200);
    push_item(OP_UPDATE, -16'sh8000);
    push_item(OP_UPDATE, 16'sh7fff);
    push_item(OP_CLEAR, -16'sh0001);
    push_item(OP_UPDATE, 16'sh0064);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin pick_wl = 7'd127; pick_mh = 16'hffff; pick_k = 8'hff; end
        1: begin pick_wl = 7'd64;  pick_mh = 16'd0;    pick_k = 8'd0;  end
        2: begin pick_wl = 7'd1;   pick_mh = 16'd40;   pick_k = 8'hff; end
        default: begin
          case ($urandom_range(0, 4))
            0: pick_wl = 7'd0;
            1: pick_wl = 7'd1;
            2: pick_wl = 7'd64;
            3: pick_wl = WLEN_BITS'($urandom_range(65, 127));
            default: pick_wl = WLEN_BITS'($urandom_range(2, 63));
          endcase
          case ($urandom_range(0, 5))
            0: pick_mh = 16'd0;
            1: pick_mh = 16'hffff;
            default: pick_mh = MINH_BITS'($urandom_range(1, 40));
          endcase
          case ($urandom_range(0, 3))
            0: pick_k = 8'd0;
            1: pick_k = 8'hff;
            default: pick_k = K_BITS'($urandom_range(1, 48));
          endcase
        end
      endcase
      write_regs(pick_wl, pick_mh, pick_k);
      gen_traffic(80);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: window_vs_baseline_drift_detector_unit.f
rtl/core/wvbd_pkg.sv
rtl/core/wvbd_if.sv
rtl/core/wvbd_ram.sv
rtl/core/wvbd_arith.sv
rtl/core/window_vs_baseline_drift_detector_unit.sv
dv/tb_top.sv
